// ----- sv/pft_pkg.sv -----
// Shared types, constants and the font table for the page framebuffer text renderer.
package pft_pkg;

    // Screen geometry and bar size
    localparam int COLUMNS    = 128;
    localparam int PAGE_COUNT = 8;
    localparam int BAR_WIDTH  = 60;

    localparam int STORE_SIZE = COLUMNS * PAGE_COUNT;
    localparam int AW         = $clog2(STORE_SIZE);

    // Field widths
    localparam int OP_W   = 3;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int PAGE_W = 3;
    localparam int CODE_W = 8;
    localparam int PCT_W  = 8;
    localparam int DATA_W = 8;

    localparam int IN_FIELDS_W  = COL_W + ROW_W + 2 * PAGE_W + CODE_W + 1 + PCT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + COL_W + PAGE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Column sum of start column plus offset; offsets stay below 128
    localparam int SUM_W = COL_W + 1;
    localparam logic [SUM_W-1:0]  COLS_L  = SUM_W'(COLUMNS);
    localparam logic [PAGE_W:0]   PAGES_L = (PAGE_W + 1)'(PAGE_COUNT);
    localparam logic [ROW_W:0]    ROWS_L  = (ROW_W + 1)'(PAGE_COUNT * 8);
    localparam logic [PAGE_W-1:0] LAST_PAGE_L = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(STORE_SIZE - 1);

    // Glyph and bar sequencing
    localparam int GLYPH_COLS = 6;
    localparam int GLYPH_BITS = 5 * DATA_W;
    localparam int K_W        = $clog2(BAR_WIDTH + 3);
    localparam logic [K_W-1:0] GLYPH_LAST_K = K_W'(GLYPH_COLS - 1);
    localparam logic [K_W-1:0] BAR_LAST_K   = K_W'(BAR_WIDTH + 1);

    // Fill = pct * BAR_WIDTH / 100 through a scaled reciprocal
    localparam int PCT_MAX    = 100;
    localparam int CPCT_W     = PCT_W - 1;
    localparam int FILL_W     = $clog2(BAR_WIDTH + 1);
    localparam int PROD_W     = CPCT_W + FILL_W;
    localparam int FILL_SHIFT = 20;
    localparam int FILL_K     = (2 ** FILL_SHIFT + PCT_MAX - 1) / PCT_MAX;
    localparam int FILL_K_W   = $clog2(FILL_K + 1);
    localparam int SCALED_W   = PROD_W + FILL_K_W;
    localparam logic [CPCT_W-1:0] PCT_MAX_L = CPCT_W'(PCT_MAX);

    localparam logic [CODE_W-1:0] FIRST_CODE    = 8'h20;
    localparam logic [CODE_W-1:0] LAST_CODE     = 8'h7E;
    localparam logic [CODE_W-1:0] FALLBACK_CODE = 8'h3F;

    localparam logic [DATA_W-1:0] BAR_END_MASK  = 8'h7E;
    localparam logic [DATA_W-1:0] BAR_EDGE_MASK = 8'h42;
    localparam logic [DATA_W-1:0] BAR_FILL_MASK = 8'h3C;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 3'd0,
        OP_GLYPH = 3'd1,
        OP_BAR   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_GLYPH,
        ST_BAR_MUL,
        ST_BAR_FILL,
        ST_BAR_RD,
        ST_BAR_WR,
        ST_CLR_SETUP,
        ST_CLR_WR,
        ST_RD_ISSUE,
        ST_RD_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] page_last;
        logic [CODE_W-1:0] char_code;
        logic              pixel_on;
        logic [PCT_W-1:0]  percent;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic [COL_W-1:0]  column;
        logic [PAGE_W-1:0] page;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [AW-1:0]     wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [AW-1:0]     rd_addr;
    } mem_req_t;

    // Five column bytes per glyph, leftmost column in the top byte
    localparam logic [GLYPH_BITS-1:0] FONT_ROM [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000,
        40'h0041360800, 40'h1008081008
    };

    function automatic logic [GLYPH_BITS-1:0] font_row(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] idx;
        if (code < FIRST_CODE || code > LAST_CODE)
            idx = FALLBACK_CODE - FIRST_CODE;
        else
            idx = code - FIRST_CODE;
        return FONT_ROM[idx[6:0]];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [PAGE_W-1:0] pg,
                                                input logic [SUM_W-1:0] col);
        return AW'(int'(pg) * COLUMNS + int'(col));
    endfunction

endpackage

// ----- sv/pft_store.sv -----
// Framebuffer byte store: one write port, one registered read port.
module pft_store
    import pft_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          mem_req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] frame_mem [STORE_SIZE];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            frame_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= frame_mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/pft_engine.sv -----
// Command sequencer with the shared column adder, clip compare and mask unit.
module pft_engine
    import pft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  cmd_t              cmd,
    input  logic              grant,
    output logic              ready,
    output result_t           result,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] rd_data
);

    state_t                  state_reg, state_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [AW-1:0]           end_reg, end_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [PAGE_W-1:0]       page_reg, page_next;
    logic [PAGE_W-1:0]       last_reg, last_next;
    logic [2:0]              bit_reg, bit_next;
    logic                    on_reg, on_next;
    logic [GLYPH_BITS-1:0]   glyph_reg, glyph_next;
    logic [CPCT_W-1:0]       pct_reg, pct_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic                    off_reg, off_next;

    logic [SUM_W-1:0]        col_sum;
    logic                    in_cols;
    logic                    page_ok;
    logic                    cmd_page_ok;
    logic                    pixel_ok;
    logic [AW-1:0]           cur_addr;
    logic [PAGE_W-1:0]       last_clip;
    logic [CPCT_W-1:0]       pct_clamp;
    logic [SCALED_W-1:0]     scaled;
    logic [DATA_W-1:0]       bit_mask;
    logic [DATA_W-1:0]       bar_mask;
    logic                    bar_go;

    // Shared unit: start column plus offset, clipped against the right edge
    assign col_sum  = SUM_W'(col_reg) + SUM_W'(k_reg);
    assign in_cols  = col_sum < COLS_L;
    assign page_ok  = {1'b0, page_reg} < PAGES_L;
    assign cur_addr = cell_addr(page_reg, col_sum);
    assign bar_go   = in_cols && (k_reg <= BAR_LAST_K);

    assign cmd_page_ok = {1'b0, cmd.page} < PAGES_L;
    assign pixel_ok    = ({1'b0, cmd.row} < ROWS_L) && ({1'b0, cmd.column} < COLS_L);
    assign last_clip   = ({1'b0, last_reg} < PAGES_L) ? last_reg : LAST_PAGE_L;

    always_comb
    begin
        if (cmd.percent[PCT_W-1])
            pct_clamp = '0;
        else if (cmd.percent[CPCT_W-1:0] > PCT_MAX_L)
            pct_clamp = PCT_MAX_L;
        else
            pct_clamp = cmd.percent[CPCT_W-1:0];
    end

    assign scaled   = SCALED_W'(prod_reg) * SCALED_W'(FILL_K);
    assign bit_mask = DATA_W'(1) << bit_reg;

    always_comb
    begin
        if (k_reg == '0 || k_reg == BAR_LAST_K)
            bar_mask = BAR_END_MASK;
        else if (k_reg <= K_W'(fill_reg))
            bar_mask = BAR_EDGE_MASK | BAR_FILL_MASK;
        else
            bar_mask = BAR_EDGE_MASK;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        end_next   = end_reg;
        col_next   = col_reg;
        page_next  = page_reg;
        last_next  = last_reg;
        bit_next   = bit_reg;
        on_next    = on_reg;
        glyph_next = glyph_reg;
        pct_next   = pct_reg;
        prod_next  = prod_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        off_next   = off_reg;
        case (state_reg)
            ST_INIT:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next  = cmd.column;
                    page_next = cmd.page;
                    last_next = cmd.page_last;
                    k_next    = '0;
                    case (op_t'(cmd.op))
                        OP_PIXEL:
                        begin
                            page_next = cmd.row[ROW_W-1:3];
                            bit_next  = cmd.row[2:0];
                            on_next   = cmd.pixel_on;
                            if (pixel_ok)
                                state_next = ST_PIX_RD;
                        end
                        OP_GLYPH:
                        begin
                            glyph_next = font_row(cmd.char_code);
                            if (cmd_page_ok)
                                state_next = ST_GLYPH;
                        end
                        OP_BAR:
                        begin
                            pct_next = pct_clamp;
                            if (cmd_page_ok)
                                state_next = ST_BAR_MUL;
                        end
                        OP_CLEAR: state_next = ST_CLR_SETUP;
                        OP_READ:  state_next = ST_RD_ISSUE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD: state_next = ST_PIX_WR;
            ST_PIX_WR: state_next = ST_IDLE;
            ST_GLYPH:
            begin
                // shift in zeros so the sixth column is the blank spacer
                glyph_next = glyph_reg << DATA_W;
                k_next     = k_reg + K_W'(1);
                if (!in_cols || k_reg == GLYPH_LAST_K)
                    state_next = ST_IDLE;
            end
            ST_BAR_MUL:
            begin
                prod_next  = PROD_W'(int'(pct_reg) * BAR_WIDTH);
                state_next = ST_BAR_FILL;
            end
            ST_BAR_FILL:
            begin
                fill_next  = scaled[FILL_SHIFT +: FILL_W];
                state_next = ST_BAR_RD;
            end
            ST_BAR_RD: state_next = bar_go ? ST_BAR_WR : ST_IDLE;
            ST_BAR_WR:
            begin
                k_next     = k_reg + K_W'(1);
                state_next = ST_BAR_RD;
            end
            ST_CLR_SETUP:
            begin
                addr_next = cell_addr(page_reg, '0);
                end_next  = cell_addr(last_clip, SUM_W'(COLUMNS - 1));
                if (page_ok && page_reg <= last_reg)
                    state_next = ST_CLR_WR;
                else
                    state_next = ST_IDLE;
            end
            ST_CLR_WR:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == end_reg)
                    state_next = ST_IDLE;
            end
            ST_RD_ISSUE:
            begin
                off_next   = !(page_ok && in_cols);
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE:
            begin
                if (grant)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        mem_req         = '0;
        mem_req.rd_addr = cur_addr;
        mem_req.wr_addr = cur_addr;
        case (state_reg)
            ST_INIT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = addr_reg;
            end
            ST_PIX_RD: mem_req.rd_en = 1'b1;
            ST_PIX_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = on_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
            end
            ST_GLYPH:
            begin
                mem_req.wr_en   = in_cols;
                mem_req.wr_data = glyph_reg[GLYPH_BITS-1 -: DATA_W];
            end
            ST_BAR_RD: mem_req.rd_en = bar_go;
            ST_BAR_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = rd_data | bar_mask;
            end
            ST_CLR_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = addr_reg;
            end
            ST_RD_ISSUE: mem_req.rd_en = page_ok && in_cols;
            default:     mem_req.rd_en = 1'b0;
        endcase
    end

    assign ready         = state_reg == ST_IDLE;
    assign result.valid  = state_reg == ST_RD_DONE;
    assign result.data   = off_reg ? '0 : rd_data;
    assign result.column = col_reg;
    assign result.page   = page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg   <= end_next;
        col_reg   <= col_next;
        page_reg  <= page_next;
        last_reg  <= last_next;
        bit_reg   <= bit_next;
        on_reg    <= on_next;
        glyph_reg <= glyph_next;
        pct_reg   <= pct_next;
        prod_reg  <= prod_next;
        fill_reg  <= fill_next;
        k_reg     <= k_next;
        off_reg   <= off_next;
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == ST_IDLE)
        else $error("item accepted while sequencer busy");

    a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR_WR |-> addr_reg <= end_reg)
        else $error("page clear ran past its last byte");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BAR_RD |-> fill_reg <= FILL_W'(BAR_WIDTH))
        else $error("bar fill exceeds bar width");

    a_glyph_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GLYPH && mem_req.wr_en) |-> k_reg <= GLYPH_LAST_K)
        else $error("glyph wrote more than six columns");

    a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_DONE && grant) |=> state_reg == ST_IDLE)
        else $error("read result not retired after handoff");

endmodule

// ----- sv/page_framebuffer_text_renderer.sv -----
// Top level: stream ports, command unpacking, result register, store and sequencer.
//
// A 128 x 8-page monochrome framebuffer (one byte per column and page, bit 0 on top)
// driven by pixel, glyph, bar, page-clear and read commands. Every command is
// processed by one sequencer that walks the columns one byte at a time through a
// single read-modify-write path into the store, so the block takes one item at a
// time: a pixel is read and written back, a glyph writes up to six columns, a bar
// computes its fill and then reads and writes each drawn column, a page clear writes
// every byte of each page, and a read waits for the result port. Ops 5 to 7 are dropped. The result register lets
// the next item be taken while a read result waits. After reset the store is
// swept to zero, during which s_axis_tready stays low.
module page_framebuffer_text_renderer
    import pft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column, row, page, page_last, char_code, pixel_on, percent, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data, read_column, read_page, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cmd_t                    cmd;
    result_t                 result;
    mem_req_t                mem_req;
    logic [DATA_W-1:0]       rd_data;
    logic                    ready;
    logic                    accept;
    logic                    grant;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_FIELDS_W-1:0] out_data_reg;

    assign cmd.op        = s_axis_tuser;
    assign cmd.column    = s_axis_tdata[COL_W-1:0];
    assign cmd.row       = s_axis_tdata[COL_W +: ROW_W];
    assign cmd.page      = s_axis_tdata[COL_W + ROW_W +: PAGE_W];
    assign cmd.page_last = s_axis_tdata[COL_W + ROW_W + PAGE_W +: PAGE_W];
    assign cmd.char_code = s_axis_tdata[COL_W + ROW_W + 2 * PAGE_W +: CODE_W];
    assign cmd.pixel_on  = s_axis_tdata[COL_W + ROW_W + 2 * PAGE_W + CODE_W];
    assign cmd.percent   = s_axis_tdata[COL_W + ROW_W + 2 * PAGE_W + CODE_W + 1 +: PCT_W];

    assign s_axis_tready = ready;
    assign accept        = s_axis_tvalid && ready;
    assign grant         = !out_valid_reg || m_axis_tready;

    pft_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    pft_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (cmd),
        .grant   (grant),
        .ready   (ready),
        .result  (result),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (result.valid && grant)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (result.valid && grant)
            out_data_reg <= {result.page, result.column, result.data};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

// ----- tb/tb_page_framebuffer_text_renderer.sv -----
`timescale 1ns / 100ps
// Testbench for the page framebuffer text renderer: random drawing commands checked by read-back.
module tb_page_framebuffer_text_renderer;
    import pft_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [CODE_W-1:0] QUESTION_CODE = 8'h3F;
    localparam int ITEM_TARGET   = 1350;
    // a full-screen clear is the slowest command
    localparam int SETTLE_CYCLES = 1100;

    // five column bytes per character, leftmost column in the top byte
    localparam logic [39:0] CHAR_SHAPES [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
    };

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] page_last;
        logic [CODE_W-1:0] char_code;
        logic              pixel_on;
        logic [PCT_W-1:0]  percent;
        bit                drain;   // hold until every read-back has arrived
        bit                rush;    // no idling on either side
    } draw_cmd_t;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [COL_W-1:0]  column;
        logic [PAGE_W-1:0] page;
    } readback_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [DATA_W-1:0] screen [0:PAGE_COUNT-1][0:COLUMNS-1];
    draw_cmd_t cmd_q[$];
    readback_t readback_q[$];
    draw_cmd_t on_bus;
    int        fail_count = 0;
    int        send_gap = 0;
    int        sink_stall = 0;
    bit        rush_mode = 1'b0;

    page_framebuffer_text_renderer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 45);
    endfunction

    function automatic draw_cmd_t any_cmd(logic [OP_W-1:0] op, int column, int page);
        draw_cmd_t c;
        c.op        = op;
        c.column    = COL_W'(column);
        c.row       = ROW_W'($urandom);
        c.page      = PAGE_W'(page);
        c.page_last = PAGE_W'($urandom);
        c.char_code = CODE_W'($urandom);
        c.pixel_on  = 1'($urandom);
        c.percent   = PCT_W'($urandom);
        c.drain     = 1'b0;
        c.rush      = 1'b0;
        return c;
    endfunction

    // Apply one accepted command to the shadow screen and queue any read-back
    task automatic render_command(input draw_cmd_t c);
        int pct;
        int fill;
        int x;
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] m;
        readback_t r;
        case (c.op)
            OP_PIXEL:
                // every row and column the fields can carry lands on screen
                screen[c.row[ROW_W-1:3]][c.column][c.row[2:0]] = c.pixel_on;
            OP_GLYPH:
            begin
                code = c.char_code;
                if (code < FIRST_CODE || code > LAST_CODE)
                    code = QUESTION_CODE;
                for (int k = 0; k < 6; k++)
                begin
                    x = int'(c.column) + k;
                    if (x >= COLUMNS)
                        break;
                    screen[c.page][x] = (k < 5) ? CHAR_SHAPES[code - FIRST_CODE][39 - 8 * k -: 8]
                                                : '0;
                end
            end
            OP_BAR:
            begin
                pct = int'($signed(c.percent));
                if (pct < 0)
                    pct = 0;
                if (pct > 100)
                    pct = 100;
                fill = pct * BAR_WIDTH / 100;
                for (int k = 0; k <= BAR_WIDTH + 1; k++)
                begin
                    x = int'(c.column) + k;
                    if (x >= COLUMNS)
                        break;
                    if (k == 0 || k == BAR_WIDTH + 1)
                        m = BAR_END_MASK;
                    else
                        m = BAR_EDGE_MASK | ((k <= fill) ? BAR_FILL_MASK : '0);
                    screen[c.page][x] = screen[c.page][x] | m;
                end
            end
            OP_CLEAR:
                for (int p = int'(c.page); p <= int'(c.page_last) && p < PAGE_COUNT; p++)
                    for (int col = 0; col < COLUMNS; col++)
                        screen[p][col] = '0;
            OP_READ:
            begin
                r.data   = screen[c.page][c.column];
                r.column = c.column;
                r.page   = c.page;
                readback_q.push_back(r);
            end
            default:
                ;
        endcase
    endtask

    // Command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                render_command(on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_q.size() > 0 && (!cmd_q[0].drain || readback_q.size() == 0))
                begin
                    on_bus = cmd_q.pop_front();
                    s_axis_tdata <= IN_DATA_W'({on_bus.percent, on_bus.pixel_on,
                                                on_bus.char_code, on_bus.page_last,
                                                on_bus.page, on_bus.row, on_bus.column});
                    s_axis_tuser <= on_bus.op;
                    s_axis_tvalid <= 1'b1;
                    rush_mode = on_bus.rush;
                    send_gap = on_bus.rush ? 0 : pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Read-back monitor
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        readback_t want;
        logic [DATA_W-1:0] got_data;
        logic [COL_W-1:0]  got_column;
        logic [PAGE_W-1:0] got_page;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_data   = m_axis_tdata[DATA_W-1:0];
                got_column = m_axis_tdata[DATA_W +: COL_W];
                got_page   = m_axis_tdata[DATA_W + COL_W +: PAGE_W];
                if (readback_q.size() == 0)
                begin
                    $display("%0t: unexpected read-back, expected none, got data %02h col %0d page %0d",
                             $time, got_data, got_column, got_page);
                    fail_count++;
                end
                else
                begin
                    want = readback_q.pop_front();
                    if (got_data !== want.data)
                    begin
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want.data, got_data);
                        fail_count++;
                    end
                    if (got_column !== want.column)
                    begin
                        $display("%0t: read_column mismatch, expected %0d, got %0d",
                                 $time, want.column, got_column);
                        fail_count++;
                    end
                    if (got_page !== want.page)
                    begin
                        $display("%0t: read_page mismatch, expected %0d, got %0d",
                                 $time, want.page, got_page);
                        fail_count++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rush_mode && $urandom_range(0, 7) == 0)
                    sink_stall = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        draw_cmd_t c;
        int counted;
        int pick;
        int last_col;
        int last_page;

        for (int p = 0; p < PAGE_COUNT; p++)
            for (int col = 0; col < COLUMNS; col++)
                screen[p][col] = '0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // corners of the screen, freshly cleared
        cmd_q.push_back(any_cmd(OP_READ, 0, 0));
        cmd_q.push_back(any_cmd(OP_READ, 127, 7));
        c = any_cmd(OP_PIXEL, 0, 0);
        c.row = 0;
        c.pixel_on = 1'b1;
        cmd_q.push_back(c);
        c = any_cmd(OP_PIXEL, 127, 0);
        c.row = 63;
        c.pixel_on = 1'b1;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 0, 0));
        cmd_q.push_back(any_cmd(OP_READ, 127, 7));
        c.pixel_on = 1'b0;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 127, 7));

        // glyphs: out-of-range codes, both printable ends, right-edge clip
        c = any_cmd(OP_GLYPH, 0, 1);
        c.char_code = 8'h00;
        cmd_q.push_back(c);
        c = any_cmd(OP_GLYPH, 6, 1);
        c.char_code = FIRST_CODE;
        cmd_q.push_back(c);
        c = any_cmd(OP_GLYPH, 12, 1);
        c.char_code = LAST_CODE;
        cmd_q.push_back(c);
        c = any_cmd(OP_GLYPH, 18, 1);
        c.char_code = LAST_CODE + 1'b1;
        cmd_q.push_back(c);
        c = any_cmd(OP_GLYPH, 125, 1);
        c.char_code = 8'hFF;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 126, 1));

        // bars: percent below zero, zero, full, above full, half, clipped
        c = any_cmd(OP_BAR, 0, 2);
        c.percent = 8'h80;
        cmd_q.push_back(c);
        c = any_cmd(OP_BAR, 0, 3);
        c.percent = 8'd0;
        cmd_q.push_back(c);
        c = any_cmd(OP_BAR, 0, 4);
        c.percent = 8'd100;
        cmd_q.push_back(c);
        c = any_cmd(OP_BAR, 70, 5);
        c.percent = 8'h7F;
        cmd_q.push_back(c);
        c = any_cmd(OP_BAR, 3, 6);
        c.percent = 8'd50;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 33, 6));
        cmd_q.push_back(any_cmd(OP_READ, 34, 6));

        // clears: empty range, single page, whole screen
        c = any_cmd(OP_CLEAR, 0, 5);
        c.page_last = 3'd2;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 70, 5));
        c = any_cmd(OP_CLEAR, 0, 4);
        c.page_last = 3'd4;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 10, 4));
        cmd_q.push_back(any_cmd(OP_SPARE_LO, 0, 0));
        cmd_q.push_back(any_cmd(OP_SPARE_HI, 127, 7));
        c = any_cmd(OP_CLEAR, 0, 0);
        c.page_last = 3'd7;
        cmd_q.push_back(c);
        cmd_q.push_back(any_cmd(OP_READ, 3, 6));

        counted = cmd_q.size() - 2;
        last_col = 0;
        last_page = 0;
        while (counted < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 24)
            begin
                c = any_cmd(OP_PIXEL, $urandom_range(0, 127), 0);
                last_col = c.column;
                last_page = c.row[ROW_W-1:3];
            end
            else if (pick < 42)
            begin
                c = any_cmd(OP_GLYPH, $urandom_range(0, 127), $urandom_range(0, 7));
                if ($urandom_range(0, 4) != 0)
                    c.char_code = CODE_W'($urandom_range(FIRST_CODE, LAST_CODE));
                last_col = c.column;
                last_page = c.page;
            end
            else if (pick < 52)
            begin
                c = any_cmd(OP_BAR, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 66)
                                                               : $urandom_range(0, 127),
                            $urandom_range(0, 7));
                if ($urandom_range(0, 4) < 3)
                    c.percent = PCT_W'($urandom_range(0, 100));
                last_col = c.column + $urandom_range(0, 55);
                last_page = c.page;
            end
            else if (pick < 56)
            begin
                c = any_cmd(OP_CLEAR, 0, $urandom_range(0, 7));
                pick = $urandom_range(0, 4);
                if (pick < 3)
                    c.page_last = c.page;
                else if (pick == 3)
                    c.page_last = 3'd7;
            end
            else if (pick < 59)
            begin
                c = any_cmd(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 0, 0);
                c.column = COL_W'($urandom);
                c.page = PAGE_W'($urandom);
            end
            else if ($urandom_range(0, 9) < 6)
            begin
                c = any_cmd(OP_READ, last_col + $urandom_range(0, 7), last_page);
            end
            else
            begin
                c = any_cmd(OP_READ, $urandom_range(0, 127), $urandom_range(0, 7));
            end
            if (c.op < OP_SPARE_LO)
            begin
                c.drain = (counted % 200 == 0);
                c.rush = (counted % 150 < 25);
                counted++;
            end
            cmd_q.push_back(c);
        end

        while (cmd_q.size() > 0 || s_axis_tvalid || readback_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
